/* rtl/ptt_pkg.sv */
package ptt_pkg;

  // Width of the stored track values; the 32-bit input is sign extended
  // and then cut to this many bits.
  localparam int VALUE_BITS = 32;

  localparam int CNT_W    = 8;
  localparam int TREND_W  = 3;
  localparam int KIND_W   = 2;
  localparam int TAG_W    = 32;
  localparam int IN_W     = 32;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic signed [IN_W-1:0]       point_value_t;
  typedef logic [KIND_W-1:0]            kind_t;
  typedef logic [TAG_W-1:0]             tag_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [TREND_W-1:0]           trend_t;

  // Point kinds
  localparam kind_t KIND_OTHER = 2'd0;
  localparam kind_t KIND_LOW   = 2'd1;
  localparam kind_t KIND_HIGH  = 2'd2;

  // Track trend codes
  localparam trend_t TREND_UNDEF  = 3'd0;
  localparam trend_t TREND_RISE   = 3'd1;
  localparam trend_t TREND_FALL   = 3'd2;
  localparam trend_t TREND_NORULE = 3'd3;
  localparam trend_t TREND_NONE   = 3'd4;

  // Composite trend codes
  localparam trend_t COMP_UNDEF   = 3'd0;
  localparam trend_t COMP_RISE    = 3'd1;
  localparam trend_t COMP_FALL    = 3'd2;
  localparam trend_t COMP_SHRINK  = 3'd3;
  localparam trend_t COMP_ENLARGE = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_LOW_MIN  = 2'd0;
  localparam logic [1:0] REG_HIGH_MIN = 2'd1;
  localparam logic [1:0] REG_RUN_LIM  = 2'd2;

  localparam cnt_t CNT_MAX = '1;

  typedef struct packed {
    cnt_t low_min_count;
    cnt_t high_min_count;
    cnt_t run_limit;
  } cfg_t;

  function automatic value_t to_key(point_value_t v);
    return value_t'(v);
  endfunction

  function automatic trend_t combine(trend_t lo, trend_t hi);
    trend_t c;
    c = COMP_UNDEF;
    if (lo == TREND_RISE && hi == TREND_RISE) c = COMP_RISE;
    else if (lo == TREND_FALL && hi == TREND_FALL) c = COMP_FALL;
    else if (lo == TREND_RISE && hi == TREND_FALL) c = COMP_SHRINK;
    else if (lo == TREND_FALL && hi == TREND_RISE) c = COMP_ENLARGE;
    return c;
  endfunction

endpackage

/* rtl/ptt_point_if.sv */
interface ptt_point_if import ptt_pkg::*; ();
  logic         valid;
  logic         ready;
  point_value_t point_value;
  kind_t        point_kind;
  tag_t         time_tag;

  modport source(output valid, point_value, point_kind, time_tag, input ready);
  modport sink(input valid, point_value, point_kind, time_tag, output ready);
endinterface

/* rtl/ptt_result_if.sv */
interface ptt_result_if import ptt_pkg::*; ();
  logic   valid;
  logic   ready;
  tag_t   time_tag_out;
  trend_t track_trend;
  trend_t composite_trend;

  modport source(output valid, time_tag_out, track_trend, composite_trend, input ready);
  modport sink(input valid, time_tag_out, track_trend, composite_trend, output ready);
endinterface

/* rtl/peak_trough_trend_classifier.sv */
// Pipeline: an accepted point passes the input register, then the result
//   register, and is held there while the result output stalls.
// Throughput: one point per cycle when results are taken; low/high track
//   update and both trend reads sit in one combinational pass in between.
// Reset (rst, synchronous, active high): both tracks cleared, registers
//   back to low/high minimum 4 and run limit 1, pipeline emptied.
module peak_trough_trend_classifier import ptt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  ptt_point_if.sink          points,
  ptt_result_if.source       results
);

  cfg_t cfg;

  // Input stage register
  logic         stage_valid;
  point_value_t stage_value;
  kind_t        stage_kind;
  tag_t         stage_tag;

  // Result register
  logic   result_valid;
  tag_t   result_tag;
  trend_t result_trend;
  trend_t result_comp;

  logic   advance;   // result register free to load this cycle
  logic   fire;      // stage beat moves into the result register
  logic   in_beat;
  value_t key;
  trend_t lo_trend, hi_trend, own_trend;

  ptt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage and result registers form a two-deep pipe; the input side keeps
  // taking beats while the result waits only as long as the stage is empty.
  assign advance      = !result_valid || results.ready;
  assign fire         = stage_valid && advance;
  assign points.ready = !stage_valid || advance;
  assign in_beat      = points.valid && points.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (points.ready) begin
      stage_valid <= points.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      stage_value <= points.point_value;
      stage_kind  <= points.point_kind;
      stage_tag   <= points.time_tag;
    end
  end

  assign key = to_key(stage_value);

  // Each track updates only when its point leaves the stage, so state moves
  // exactly once per beat no matter how long the output stalls.
  ptt_track u_low (
    .clk       (clk),
    .rst       (rst),
    .upd       (fire && stage_kind == KIND_LOW),
    .key       (key),
    .min_count (cfg.low_min_count),
    .run_limit (cfg.run_limit),
    .trend     (lo_trend)
  );

  ptt_track u_high (
    .clk       (clk),
    .rst       (rst),
    .upd       (fire && stage_kind == KIND_HIGH),
    .key       (key),
    .min_count (cfg.high_min_count),
    .run_limit (cfg.run_limit),
    .trend     (hi_trend)
  );

  // Kind 3 is handled like "other".
  always_comb begin
    case (stage_kind)
      KIND_LOW:  own_trend = lo_trend;
      KIND_HIGH: own_trend = hi_trend;
      default:   own_trend = TREND_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_tag   <= stage_tag;
      result_trend <= own_trend;
      result_comp  <= combine(lo_trend, hi_trend);
    end
  end

  assign results.valid           = result_valid;
  assign results.time_tag_out    = result_tag;
  assign results.track_trend     = result_trend;
  assign results.composite_trend = result_comp;

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && result_valid && !results.ready) |-> !points.ready)
    else $error("input taken with both stages full");

  a_fire_shows: assert property (@(posedge clk) disable iff (rst)
    fire |=> result_valid)
    else $error("stage beat lost on the way to the result register");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(stage_valid))
    else $error("result appeared without a staged point");

endmodule

/* rtl/ptt_cfg.sv */
module ptt_cfg import ptt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_min_count  <= 8'd4;
      cfg.high_min_count <= 8'd4;
      cfg.run_limit      <= 8'd1;
    end else if (wr) begin
      case (idx)
        REG_LOW_MIN:  cfg.low_min_count  <= pwdata[CNT_W-1:0];
        REG_HIGH_MIN: cfg.high_min_count <= pwdata[CNT_W-1:0];
        REG_RUN_LIM:  cfg.run_limit      <= pwdata[CNT_W-1:0];
        default: ;  // unmapped, write ignored
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LOW_MIN:  prdata = PDATA_W'(cfg.low_min_count);
      REG_HIGH_MIN: prdata = PDATA_W'(cfg.high_min_count);
      REG_RUN_LIM:  prdata = PDATA_W'(cfg.run_limit);
      default:      prdata = '0;
    endcase
  end

endmodule

/* rtl/ptt_track.sv */
module ptt_track import ptt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   upd,
  input  value_t key,
  input  cnt_t   min_count,
  input  cnt_t   run_limit,
  output trend_t trend
);

  cnt_t   count, count_next;
  value_t last;
  cnt_t   rise, rise_next;
  cnt_t   fall, fall_next;
  cnt_t   rc, rr, rf;

  // Pair of the first two points is not counted; ties leave runs alone.
  always_comb begin
    rise_next  = rise;
    fall_next  = fall;
    count_next = (count == CNT_MAX) ? count : count + cnt_t'(1);
    if (count >= cnt_t'(2)) begin
      if (key > last) begin
        rise_next = (rise == CNT_MAX) ? rise : rise + cnt_t'(1);
        fall_next = '0;
      end else if (key < last) begin
        fall_next = (fall == CNT_MAX) ? fall : fall + cnt_t'(1);
        rise_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      last  <= '0;
      rise  <= '0;
      fall  <= '0;
    end else if (upd) begin
      count <= count_next;
      last  <= key;
      rise  <= rise_next;
      fall  <= fall_next;
    end
  end

  // Trend reflects the state after this beat's update.
  assign rc = upd ? count_next : count;
  assign rr = upd ? rise_next  : rise;
  assign rf = upd ? fall_next  : fall;

  always_comb begin
    if (rc < min_count)      trend = TREND_UNDEF;
    else if (rr > run_limit) trend = TREND_RISE;
    else if (rf > run_limit) trend = TREND_FALL;
    else                     trend = TREND_NORULE;
  end

  a_runs_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(rise != '0 && fall != '0))
    else $error("rise and fall runs both active");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    (count == CNT_MAX) |=> (count == CNT_MAX))
    else $error("point count wrapped");

endmodule

/* tb/tb_peak_trough_trend_classifier.sv */
module tb_peak_trough_trend_classifier;
  import ptt_pkg::*;

  // Run control
  localparam int WATCHDOG    = 3000;  // cycles with no beat on either channel
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off in the pressure phase
  localparam int DRAIN_PAUSE = 4;     // settle wait once both queues are empty
  localparam int REPORT_MAX  = 10;

  // Kind code 3 is unused; the block must treat it like "other".
  localparam kind_t KIND_UNUSED = 2'd3;
  // Register index with no register behind it.
  localparam logic [1:0] REG_NONE = 2'd3;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  ptt_point_if  pt_if ();
  ptt_result_if rs_if ();

  peak_trough_trend_classifier dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .points  (pt_if),
    .results (rs_if)
  );

  // One point beat as queued for the sender. chk marks a row whose result is
  // typed in by hand; all other beats are checked against the predictor.
  typedef struct packed {
    point_value_t value;
    kind_t        kind;
    tag_t         tag;
    logic         chk;
    trend_t       track;
    trend_t       comp;
  } point_row_t;

  typedef struct {
    tag_t   tag;
    trend_t track;
    trend_t comp;
  } trend_res_t;

  // One track of the predictor: count, last value and the two run counters.
  typedef struct {
    cnt_t   count;
    value_t last;
    cnt_t   rise;
    cnt_t   fall;
  } track_state_t;

  // Directed rows, walked from reset (minimum counts 4, run limit 1).
  // The low track climbs min..max, the high track falls max..min, then
  // equal values, a reversal of each track and the unused kind.
  point_row_t dir_tab [20] = '{
    '{32'sd0,           KIND_OTHER,  32'h0000_0000, 1'b1, TREND_NONE,   COMP_UNDEF},
    '{-32'sd1,          KIND_UNUSED, 32'hFFFF_FFFF, 1'b1, TREND_NONE,   COMP_UNDEF},
    '{32'sh8000_0000,   KIND_LOW,    32'h0000_0002, 1'b1, TREND_UNDEF,  COMP_UNDEF},
    '{-32'sd100,        KIND_LOW,    32'h0000_0003, 1'b1, TREND_UNDEF,  COMP_UNDEF},
    '{32'sd0,           KIND_LOW,    32'h0000_0004, 1'b1, TREND_UNDEF,  COMP_UNDEF},
    '{32'sh7FFF_FFFF,   KIND_LOW,    32'h0000_0005, 1'b1, TREND_RISE,   COMP_UNDEF},
    '{32'sh7FFF_FFFF,   KIND_HIGH,   32'h0000_0006, 1'b1, TREND_UNDEF,  COMP_UNDEF},
    '{32'sd100,         KIND_HIGH,   32'h0000_0007, 1'b1, TREND_UNDEF,  COMP_UNDEF},
    '{32'sd0,           KIND_HIGH,   32'h0000_0008, 1'b1, TREND_UNDEF,  COMP_UNDEF},
    '{32'sh8000_0000,   KIND_HIGH,   32'h0000_0009, 1'b1, TREND_FALL,   COMP_SHRINK},
    '{32'sd12345,       KIND_OTHER,  32'h0000_000A, 1'b1, TREND_NONE,   COMP_SHRINK},
    '{32'sh7FFF_FFFF,   KIND_LOW,    32'h0000_000B, 1'b1, TREND_RISE,   COMP_SHRINK},
    '{32'sd0,           KIND_LOW,    32'h0000_000C, 1'b1, TREND_NORULE, COMP_UNDEF},
    '{-32'sd5,          KIND_LOW,    32'h0000_000D, 1'b1, TREND_FALL,   COMP_FALL},
    '{32'sd5,           KIND_HIGH,   32'h0000_000E, 1'b1, TREND_NORULE, COMP_UNDEF},
    '{32'sd6,           KIND_HIGH,   32'h0000_000F, 1'b1, TREND_RISE,   COMP_ENLARGE},
    '{32'sd6,           KIND_HIGH,   32'h0000_0010, 1'b1, TREND_RISE,   COMP_ENLARGE},
    '{32'shDEAD_BEEF,   KIND_UNUSED, 32'h5A5A_A5A5, 1'b0, TREND_UNDEF,  COMP_UNDEF},
    '{32'sh5555_5555,   KIND_LOW,    32'hA5A5_5A5A, 1'b0, TREND_UNDEF,  COMP_UNDEF},
    '{32'shAAAA_AAAA,   KIND_HIGH,   32'h1234_5678, 1'b0, TREND_UNDEF,  COMP_UNDEF}
  };

  // Predictor state and its copy of the registers
  track_state_t low_trk;
  track_state_t high_trk;
  cfg_t         cfg;

  point_row_t point_q [$];      // beats waiting to be sent
  trend_res_t trend_exp_q [$];  // results still owed by the block

  int  errors;
  int  idle_cnt;
  int  idle_pct;   // sender: chance in 100 of an idle cycle
  int  stall_pct;  // receiver: chance in 100 of a stall cycle
  bit  hold_go;
  bit  hold_on;
  logic pt_fire;

  // Generator state: each track walks up or down with random steps.
  int gen_low;
  int gen_high;
  int dir_low;
  int dir_high;

  function automatic cnt_t bump(cnt_t x);
    return (x == CNT_MAX) ? x : cnt_t'(x + 1'b1);
  endfunction

  // A step is only counted once the track already holds two points.
  function automatic track_state_t advance_track(track_state_t t, value_t key);
    track_state_t n;
    n = t;
    if (t.count >= 2) begin
      if (key > t.last) begin
        n.rise = bump(t.rise);
        n.fall = '0;
      end else if (key < t.last) begin
        n.fall = bump(t.fall);
        n.rise = '0;
      end
    end
    n.last  = key;
    n.count = bump(t.count);
    return n;
  endfunction

  function automatic trend_t read_track(track_state_t t, cnt_t min_cnt);
    if (t.count < min_cnt) return TREND_UNDEF;
    if (t.rise > cfg.run_limit) return TREND_RISE;
    if (t.fall > cfg.run_limit) return TREND_FALL;
    return TREND_NORULE;
  endfunction

  function automatic trend_t pair_trends(trend_t lo, trend_t hi);
    if (lo == TREND_RISE)
      return (hi == TREND_RISE) ? COMP_RISE : (hi == TREND_FALL) ? COMP_SHRINK : COMP_UNDEF;
    if (lo == TREND_FALL)
      return (hi == TREND_FALL) ? COMP_FALL : (hi == TREND_RISE) ? COMP_ENLARGE : COMP_UNDEF;
    return COMP_UNDEF;
  endfunction

  // Update the tracks with one point and return the trends it should give.
  function automatic trend_res_t classify_point(point_value_t v, kind_t k, tag_t tag);
    logic signed [63:0] wide;
    value_t     key;
    trend_res_t r;
    wide = v;  // sign extend, then keep VALUE_BITS
    key  = value_t'(wide[VALUE_BITS-1:0]);
    r.tag   = tag;
    r.track = TREND_NONE;
    if (k == KIND_LOW) begin
      low_trk = advance_track(low_trk, key);
      r.track = read_track(low_trk, cfg.low_min_count);
    end else if (k == KIND_HIGH) begin
      high_trk = advance_track(high_trk, key);
      r.track = read_track(high_trk, cfg.high_min_count);
    end
    r.comp = pair_trends(read_track(low_trk, cfg.low_min_count),
                         read_track(high_trk, cfg.high_min_count));
    return r;
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= REPORT_MAX) $display("%0t: mismatch: %s", $realtime, msg);
  endtask

  // Clock: period 12
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, or a solid hold-off while hold_on is set.
  always @(negedge clk) begin
    if (rst) rs_if.ready <= 1'b0;
    else if (hold_on) rs_if.ready <= 1'b0;
    else rs_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Long hold-off, counted here so the sender keeps offering beats meanwhile.
  initial begin
    hold_on = 1'b0;
    wait (hold_go);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_on = 1'b0;
  end

  // Sender: a beat on offer stays put until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      pt_if.valid <= 1'b0;
    end else if (!(pt_if.valid && !pt_fire)) begin
      if (point_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        pt_if.valid       <= 1'b1;
        pt_if.point_value <= point_q[0].value;
        pt_if.point_kind  <= point_q[0].kind;
        pt_if.time_tag    <= point_q[0].tag;
      end else begin
        pt_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: results are checked before the input beat of the same edge is
  // predicted; a result never belongs to a beat taken at the same edge.
  always @(posedge clk) begin : mon
    trend_res_t want;
    trend_res_t got;
    pt_fire <= pt_if.valid && pt_if.ready && !rst;
    if (!rst) begin
      if (rs_if.valid && rs_if.ready) begin
        got.tag   = rs_if.time_tag_out;
        got.track = rs_if.track_trend;
        got.comp  = rs_if.composite_trend;
        if (trend_exp_q.size() == 0) begin
          note_error($sformatf("unexpected result tag=%h track=%0d comp=%0d",
                               got.tag, got.track, got.comp));
        end else begin
          want = trend_exp_q.pop_front();
          if (got.tag !== want.tag || got.track !== want.track || got.comp !== want.comp)
            note_error($sformatf("tag %h/%h track %0d/%0d comp %0d/%0d (expected/actual)",
                                 want.tag, got.tag, want.track, got.track,
                                 want.comp, got.comp));
        end
      end
      if (pt_if.valid && pt_if.ready) begin
        want = classify_point(pt_if.point_value, pt_if.point_kind, pt_if.time_tag);
        if (point_q.size() != 0) begin
          if (point_q[0].chk) begin
            want.track = point_q[0].track;
            want.comp  = point_q[0].comp;
          end
          void'(point_q.pop_front());
        end
        trend_exp_q = {trend_exp_q, want};
      end
    end
  end

  // Watchdog: too long without a beat on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (pt_if.valid && pt_if.ready) || (rs_if.valid && rs_if.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // Register write: setup cycle, then access cycle; pready is always high.
  task automatic reg_write(logic [1:0] idx, cnt_t val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), val};  // only the low byte is kept
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_LOW_MIN:  cfg.low_min_count  = val;
      REG_HIGH_MIN: cfg.high_min_count = val;
      REG_RUN_LIM:  cfg.run_limit      = val;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(cnt_t lo_min, cnt_t hi_min, cnt_t lim);
    reg_write(REG_LOW_MIN, lo_min);
    reg_write(REG_HIGH_MIN, hi_min);
    reg_write(REG_RUN_LIM, lim);
  endtask

  // Mostly well-formed track walks, some raw noise on every bit.
  task automatic push_random_point();
    point_row_t p;
    int r;
    int step;
    p     = '0;
    p.tag = $urandom;
    r     = $urandom_range(0, 99);
    step  = ($urandom_range(0, 3) == 0) ? 0 :
            ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32'h00FF_FFFF) :
            $urandom_range(1, 1000);
    if (r < 15) begin
      p.value = $urandom;
      p.kind  = kind_t'($urandom_range(0, 3));
    end else if (r < 25) begin
      p.value = $urandom;
      p.kind  = KIND_OTHER;
    end else if (r < 62) begin
      if ($urandom_range(0, 99) < 15) dir_low = -dir_low;
      gen_low = gen_low + dir_low * step;
      p.value = gen_low;
      p.kind  = KIND_LOW;
    end else begin
      if ($urandom_range(0, 99) < 15) dir_high = -dir_high;
      gen_high = gen_high + dir_high * step;
      p.value  = gen_high;
      p.kind   = KIND_HIGH;
    end
    point_q = {point_q, p};
  endtask

  task automatic drain();
    while (point_q.size() != 0 || trend_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic run_random(int n, int idle, int stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) push_random_point();
    drain();
  endtask

  initial begin : main
    point_row_t p;
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    pt_if.valid = 1'b0;
    pt_if.point_value = '0;
    pt_if.point_kind  = KIND_OTHER;
    pt_if.time_tag    = '0;
    rs_if.ready = 1'b0;
    pt_fire     = 1'b0;
    errors      = 0;
    idle_cnt    = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_go     = 1'b0;
    gen_low     = -1000;
    gen_high    = 1000;
    dir_low     = 1;
    dir_high    = -1;
    low_trk     = '{count: '0, last: '0, rise: '0, fall: '0};
    high_trk    = '{count: '0, last: '0, rise: '0, fall: '0};
    cfg         = '{low_min_count: 8'd4, high_min_count: 8'd4, run_limit: 8'd1};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows against the reset register values, no idling.
    foreach (dir_tab[i]) point_q = {point_q, dir_tab[i]};
    drain();

    // Random phases, one per idling pattern, each under other settings.
    set_config(8'd2, 8'd3, 8'd0);
    run_random(25, 0, 0);

    set_config(8'd0, 8'd0, 8'd255);  // largest limit: no run ever calls a trend
    reg_write(REG_NONE, 8'($urandom));
    run_random(25, 69, 0);

    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 254)));
    run_random(25, 0, 69);

    set_config(8'd1, 8'd1, 8'd2);
    run_random(25, 37, 37);

    // Pressure: receiver holds off while the sender keeps offering beats,
    // so the pipeline fills and backs up into the point channel.
    set_config(8'd3, 8'd3, 8'd1);
    idle_pct  = 0;
    stall_pct = 0;
    hold_go   = 1'b1;
    repeat (20) push_random_point();
    drain();

    // Saturation: a long climbing low run drives the low count and rise run
    // to 255; a limit of 254 still calls the trend.
    set_config(8'd255, 8'd255, 8'd254);
    reg_write(REG_NONE, 8'($urandom));
    idle_pct  = 20;
    stall_pct = 20;
    for (int i = 0; i < 260; i++) begin
      p       = '0;
      p.tag   = $urandom;
      p.kind  = KIND_LOW;
      p.value = -2147483000 + i * 1000;
      point_q = {point_q, p};
    end
    drain();

    // Extra tail so a stray result would still be caught.
    repeat (20) @(posedge clk);
    if (errors == 0 && trend_exp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
